### rtl/core/imhq_pkg.sv
// Package for the indexed min-heap queue unit.
// Types, constants and state encodings; no dependencies.
package imhq_pkg;

    localparam int CAPACITY = 1024;
    localparam int SLOT_W   = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int ID_W     = 10;
    localparam int ID_SPACE = 1 << ID_W;
    localparam int KEY_W    = 31;
    localparam int CNT_W    = 11;

    typedef enum logic [1:0] {
        CMD_INSERT   = 2'd0,
        CMD_EXTRACT  = 2'd1,
        CMD_DECREASE = 2'd2,
        CMD_NOP      = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_FULL        = 3'd1,
        ST_EMPTY       = 3'd2,
        ST_ABSENT      = 3'd3,
        ST_NOT_SMALLER = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAP_RD,
        S_DECIDE,
        S_KEY_CHK,
        S_UP_RD,
        S_UP_CMP,
        S_EX_RD,
        S_EX_ROOT,
        S_EX_LAST,
        S_DN_RD,
        S_DN_RD2,
        S_DN_CMP,
        S_FIN_RD,
        S_FIN,
        S_CLEAR
    } t_state;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  item_id;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0]  taken_id;
        logic [KEY_W-1:0] taken_key;
        logic [ID_W-1:0]  min_id;
        logic [KEY_W-1:0] min_key;
        logic [CNT_W-1:0] entry_count;
        logic             is_empty;
        logic [2:0]       status;
    } t_out_item;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } t_entry;

endpackage

### rtl/core/imhq_ram.sv
// Generic single-port-write, single-read synchronous RAM, registered read.
// No dependencies.
module imhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

### rtl/core/indexed_min_heap_queue_unit.sv
// Top level of the indexed min-heap queue unit.
// Uses imhq_pkg and imhq_ram (heap entry store and id-to-slot map).
//
//  channel | signals                   | payload
//  in      | i_in_valid / o_in_ready   | i_in  (cmd, key, item_id)
//  out     | o_out_valid / i_out_ready | o_out (taken, min, count, status)
//
// One item at a time. Insert and decrease sift up (k sift-up swaps, states
// S_UP_RD and S_UP_CMP per level), extract sifts down (k sift-down swaps,
// states S_DN_RD, S_DN_RD2 and S_DN_CMP per level); error and unused
// commands skip the sift. After reset the id map is cleared one entry a
// cycle, with o_in_ready low. A result not yet taken holds the next one in
// its last state.
module indexed_min_heap_queue_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  imhq_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output imhq_pkg::t_out_item o_out
);
    import imhq_pkg::*;

    t_state r_state, n_state;
    t_in_item r_item;
    logic [SLOT_W-1:0] r_cnt, n_cnt;
    logic [SLOT_W-1:0] r_pos, n_pos;
    t_entry r_cur, n_cur;
    t_entry r_lch, n_lch;
    t_entry r_taken, n_taken;
    logic [2:0] r_status, n_status;
    logic [ID_W-1:0] r_clr, n_clr;
    logic r_out_v, n_out_v;
    t_out_item r_out, n_out;

    // entry RAM (slot-1 addressing)
    logic e_we;
    logic [ADDR_W-1:0] e_waddr, e_raddr;
    t_entry e_wdata, e_rdata;
    // map RAM
    logic m_we;
    logic [ID_W-1:0] m_waddr, m_raddr;
    logic [SLOT_W-1:0] m_wdata, m_rdata;

    imhq_ram #(.WIDTH($bits(t_entry)), .DEPTH(CAPACITY)) u_heap (
        .i_clk, .i_we(e_we), .i_waddr(e_waddr), .i_wdata(e_wdata),
        .i_raddr(e_raddr), .o_rdata(e_rdata)
    );
    imhq_ram #(.WIDTH(SLOT_W), .DEPTH(ID_SPACE)) u_map (
        .i_clk, .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_raddr(m_raddr), .o_rdata(m_rdata)
    );

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] t;
        t = s - SLOT_W'(1);
        return t[ADDR_W-1:0];
    endfunction

    logic [SLOT_W-1:0] w_par, w_lc, w_rc;
    assign w_par = r_pos >> 1;
    assign w_lc  = r_pos << 1;
    assign w_rc  = (r_pos << 1) | SLOT_W'(1);

    logic w_held, w_up_move, w_out_free;
    assign w_held     = (m_rdata != '0) && (m_rdata <= r_cnt);
    assign w_up_move  = (r_pos > SLOT_W'(1)) && (e_rdata.key > r_cur.key);
    assign w_out_free = !r_out_v || i_out_ready;

    // sift-down choice: left child wins ties
    logic [SLOT_W-1:0] w_best;
    logic [KEY_W-1:0] w_bk;
    always_comb begin
        w_best = r_pos;
        w_bk   = r_cur.key;
        if (r_lch.key < w_bk) begin
            w_best = w_lc;
            w_bk   = r_lch.key;
        end
        if (w_rc <= r_cnt && e_rdata.key < w_bk) begin
            w_best = w_rc;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_clr   <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_clr   <= n_clr;
            r_out_v <= n_out_v;
        end
        r_pos    <= n_pos;
        r_cur    <= n_cur;
        r_lch    <= n_lch;
        r_taken  <= n_taken;
        r_status <= n_status;
        r_out    <= n_out;
        if (o_in_ready && i_in_valid) begin
            r_item <= i_in;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr == ID_W'(ID_SPACE - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (t_cmd'(i_in.cmd) == CMD_EXTRACT) ? S_EX_RD : S_MAP_RD;
                end
            end
            S_MAP_RD: n_state = S_DECIDE;
            S_DECIDE: begin
                if (t_cmd'(r_item.cmd) == CMD_NOP) begin
                    n_state = S_FIN_RD;
                end else if (w_held) begin
                    n_state = S_KEY_CHK;
                end else if (t_cmd'(r_item.cmd) == CMD_INSERT
                             && r_cnt < SLOT_W'(CAPACITY)) begin
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_FIN_RD;
                end
            end
            S_KEY_CHK: n_state = (r_cur.key < e_rdata.key) ? S_UP_RD : S_FIN_RD;
            S_UP_RD:   n_state = S_UP_CMP;
            S_UP_CMP:  n_state = w_up_move ? S_UP_RD : S_FIN_RD;
            S_EX_RD:   n_state = (r_cnt == '0) ? S_FIN_RD : S_EX_ROOT;
            S_EX_ROOT: n_state = (r_cnt == SLOT_W'(1)) ? S_FIN_RD : S_EX_LAST;
            S_EX_LAST: n_state = S_DN_RD;
            S_DN_RD:   n_state = (w_lc > r_cnt) ? S_FIN_RD : S_DN_RD2;
            S_DN_RD2:  n_state = S_DN_CMP;
            S_DN_CMP:  n_state = (w_best == r_pos) ? S_FIN_RD : S_DN_RD;
            S_FIN_RD:  n_state = S_FIN;
            S_FIN:     if (w_out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_cnt    = r_cnt;
        n_pos    = r_pos;
        n_cur    = r_cur;
        n_lch    = r_lch;
        n_taken  = r_taken;
        n_status = r_status;
        n_clr    = r_clr;
        n_out_v  = r_out_v;
        n_out    = r_out;
        e_we = 1'b0; e_waddr = '0; e_wdata = r_cur; e_raddr = '0;
        m_we = 1'b0; m_waddr = '0; m_wdata = '0; m_raddr = r_item.item_id;
        if (r_out_v && i_out_ready) n_out_v = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                m_we = 1'b1; m_waddr = r_clr; m_wdata = '0;
                n_clr = r_clr + ID_W'(1);
            end
            S_IDLE: begin
                m_raddr  = i_in.item_id;
                n_status = 3'(ST_OK);
                n_taken  = '0;
            end
            S_DECIDE: begin
                e_raddr = slot_addr(m_rdata);
                n_cur   = '{key: r_item.key, id: r_item.item_id};
                if (t_cmd'(r_item.cmd) == CMD_NOP) begin
                    n_status = 3'(ST_OK);
                end else if (w_held) begin
                    n_pos = m_rdata;
                end else if (t_cmd'(r_item.cmd) == CMD_INSERT) begin
                    if (r_cnt < SLOT_W'(CAPACITY)) begin
                        n_cnt = r_cnt + SLOT_W'(1);
                        n_pos = r_cnt + SLOT_W'(1);
                    end else begin
                        n_status = 3'(ST_FULL);
                    end
                end else begin
                    n_status = 3'(ST_ABSENT);
                end
            end
            S_KEY_CHK: begin
                // e_rdata is the held entry
                if (!(r_cur.key < e_rdata.key)) n_status = 3'(ST_NOT_SMALLER);
            end
            S_UP_RD: begin
                e_raddr = slot_addr(w_par);
            end
            S_UP_CMP: begin
                e_we = 1'b1; e_waddr = slot_addr(r_pos);
                m_we = 1'b1; m_wdata = r_pos;
                if (w_up_move) begin
                    // move parent down, climb
                    e_wdata = e_rdata; m_waddr = e_rdata.id;
                    n_pos = w_par;
                end else begin
                    e_wdata = r_cur; m_waddr = r_cur.id;
                end
            end
            S_EX_RD: begin
                e_raddr = '0;
                if (r_cnt == '0) n_status = 3'(ST_EMPTY);
            end
            S_EX_ROOT: begin
                // e_rdata is the root: take it, clear its map entry, fetch last
                n_taken = e_rdata;
                m_we = 1'b1; m_waddr = e_rdata.id; m_wdata = '0;
                e_raddr = slot_addr(r_cnt);
                n_cnt = r_cnt - SLOT_W'(1);
                n_pos = SLOT_W'(1);
            end
            S_EX_LAST: begin
                n_cur = e_rdata;
            end
            S_DN_RD: begin
                e_raddr = slot_addr(w_lc);
                if (w_lc > r_cnt) begin
                    e_we = 1'b1; e_waddr = slot_addr(r_pos); e_wdata = r_cur;
                    m_we = 1'b1; m_waddr = r_cur.id; m_wdata = r_pos;
                end
            end
            S_DN_RD2: begin
                e_raddr = slot_addr(w_rc);
                n_lch   = e_rdata;
            end
            S_DN_CMP: begin
                e_we = 1'b1; e_waddr = slot_addr(r_pos);
                m_we = 1'b1; m_wdata = r_pos;
                n_pos = w_best;
                if (w_best == r_pos) begin
                    e_wdata = r_cur; m_waddr = r_cur.id;
                end else if (w_best == w_lc) begin
                    e_wdata = r_lch; m_waddr = r_lch.id;
                end else begin
                    e_wdata = e_rdata; m_waddr = e_rdata.id;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_out.taken_id    = r_taken.id;
                    n_out.taken_key   = r_taken.key;
                    n_out.min_id      = (r_cnt != '0) ? e_rdata.id : '0;
                    n_out.min_key     = (r_cnt != '0) ? e_rdata.key : '0;
                    n_out.entry_count = CNT_W'(r_cnt);
                    n_out.is_empty    = (r_cnt == '0);
                    n_out.status      = r_status;
                    n_out_v           = 1'b1;
                end
            end
            default: ;
        endcase
    end

    property p_ready_idle;
        @(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == S_IDLE);
    endproperty
    a_ready_idle: assert property (p_ready_idle) else $error("ready outside idle");

    property p_cnt_cap;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= SLOT_W'(CAPACITY);
    endproperty
    a_cnt_cap: assert property (p_cnt_cap) else $error("count above capacity");

    property p_out_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out));
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result dropped");
endmodule

### tb/tb.sv
// Testbench for indexed_min_heap_queue_unit: drives insert, extract and
// decrease-key items and checks every result against an in-bench heap model.
// Depends on imhq_pkg and the unit RTL.
module tb;
    import imhq_pkg::*;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    indexed_min_heap_queue_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out(out_item)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // heap model
    logic [KEY_W-1:0]  hkey [1:CAPACITY];
    logic [ID_W-1:0]   hid  [1:CAPACITY];
    int unsigned       slot_map [ID_SPACE];
    int unsigned       held = 0;

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    int        fail_cnt = 0;
    int        results_seen = 0;
    int        max_held = 0;
    int        hold_off = 0;
    bit        drain_pause = 0;

    function automatic void queue_item(t_in_item it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic void place(int unsigned s, logic [KEY_W-1:0] k, logic [ID_W-1:0] i);
        hkey[s] = k;
        hid[s] = i;
        slot_map[i] = s;
    endfunction

    function automatic void swap_entries(int unsigned a, int unsigned b);
        logic [KEY_W-1:0] k;
        logic [ID_W-1:0]  i;
        k = hkey[a];
        i = hid[a];
        place(a, hkey[b], hid[b]);
        place(b, k, i);
    endfunction

    function automatic void bubble_up(int unsigned p);
        while (p > 1 && hkey[p/2] > hkey[p]) begin
            swap_entries(p, p/2);
            p = p / 2;
        end
    endfunction

    function automatic void bubble_down(int unsigned p);
        int unsigned l, r, b;
        forever begin
            l = 2*p;
            r = 2*p + 1;
            b = p;
            if (l <= held && hkey[l] < hkey[b]) b = l;
            if (r <= held && hkey[r] < hkey[b]) b = r;
            if (b == p) return;
            swap_entries(p, b);
            p = b;
        end
    endfunction

    function automatic t_status lower_key(logic [KEY_W-1:0] k, logic [ID_W-1:0] i);
        int unsigned s;
        s = slot_map[i];
        if (s == 0 || s > held) return ST_ABSENT;
        if (k >= hkey[s]) return ST_NOT_SMALLER;
        hkey[s] = k;
        bubble_up(s);
        return ST_OK;
    endfunction

    function automatic t_out_item heap_apply(t_in_item it);
        t_out_item r;
        int unsigned s;
        r = '0;
        r.status = ST_OK;
        case (t_cmd'(it.cmd))
            CMD_INSERT: begin
                s = slot_map[it.item_id];
                if (s != 0 && s <= held) r.status = lower_key(it.key, it.item_id);
                else if (held >= CAPACITY) r.status = ST_FULL;
                else begin
                    held++;
                    place(held, it.key, it.item_id);
                    bubble_up(held);
                end
            end
            CMD_EXTRACT: begin
                if (held == 0) r.status = ST_EMPTY;
                else begin
                    r.taken_key = hkey[1];
                    r.taken_id = hid[1];
                    slot_map[hid[1]] = 0;
                    if (held > 1) place(1, hkey[held], hid[held]);
                    held--;
                    if (held > 1) bubble_down(1);
                end
            end
            CMD_DECREASE: r.status = lower_key(it.key, it.item_id);
            default: ;
        endcase
        if (held > 0) begin
            r.min_id = hid[1];
            r.min_key = hkey[1];
        end
        r.entry_count = held[CNT_W-1:0];
        r.is_empty = (held == 0);
        if (held > max_held) max_held = held;
        return r;
    endfunction

    function automatic int short_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // driver
    int in_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && in_ready) begin
                expected_results.insert(expected_results.size(), heap_apply(in_item));
            end
            if (in_valid && !in_ready) begin
                // hold
            end else if (in_gap > 0) begin
                in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end else if (drain_pause && expected_results.size() > 0) begin
                in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                in_item <= pending_items.pop_front();
                in_valid <= 1'b1;
                in_gap <= short_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    t_out_item want;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: %p", out_item);
                    fail_cnt++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_item.taken_id !== want.taken_id) begin
                        $error("taken_id exp %0d got %0d", want.taken_id, out_item.taken_id);
                        fail_cnt++;
                    end
                    if (out_item.taken_key !== want.taken_key) begin
                        $error("taken_key exp %0d got %0d", want.taken_key, out_item.taken_key);
                        fail_cnt++;
                    end
                    if (out_item.min_id !== want.min_id) begin
                        $error("min_id exp %0d got %0d", want.min_id, out_item.min_id);
                        fail_cnt++;
                    end
                    if (out_item.min_key !== want.min_key) begin
                        $error("min_key exp %0d got %0d", want.min_key, out_item.min_key);
                        fail_cnt++;
                    end
                    if (out_item.entry_count !== want.entry_count) begin
                        $error("entry_count exp %0d got %0d", want.entry_count,
                               out_item.entry_count);
                        fail_cnt++;
                    end
                    if (out_item.is_empty !== want.is_empty) begin
                        $error("is_empty exp %0d got %0d", want.is_empty, out_item.is_empty);
                        fail_cnt++;
                    end
                    if (out_item.status !== want.status) begin
                        $error("status exp %0d got %0d", want.status, out_item.status);
                        fail_cnt++;
                    end
                end
            end
            if (results_seen == 300 && out_valid && out_ready) begin
                out_ready <= 1'b0;
                hold_off <= 400;
            end else if (hold_off > 0) begin
                out_ready <= 1'b0;
                hold_off <= hold_off - 1;
            end else if ($urandom_range(0, 29) == 0) begin
                out_ready <= 1'b0;
                hold_off <= $urandom_range(5, 30);
            end else begin
                out_ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    function automatic t_in_item mk(t_cmd c, int unsigned k, int unsigned i);
        t_in_item it;
        it.cmd = c;
        it.key = KEY_W'(k);
        it.item_id = ID_W'(i);
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge i_clk);
    endtask

    // random id pools make decrease and duplicate insert hit held ids often
    function automatic logic [ID_W-1:0] pick_id(int unsigned span);
        return ID_W'($urandom_range(0, span));
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 5))
            0: return '1;
            1: return '0;
            2: return KEY_W'($urandom_range(0, 15));
            default: return KEY_W'($urandom() >> 1);
        endcase
    endfunction

    initial begin
        int n;
        int unsigned span;
        t_cmd c;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed
        queue_item(mk(CMD_EXTRACT, 0, 0));
        queue_item(mk(CMD_DECREASE, 5, 7));
        queue_item(mk(CMD_INSERT, '1, 1023));
        queue_item(mk(CMD_INSERT, 0, 0));
        queue_item(mk(CMD_INSERT, 100, 5));
        queue_item(mk(CMD_INSERT, 100, 6));
        queue_item(mk(CMD_INSERT, 100, 7));
        queue_item(mk(CMD_DECREASE, 100, 6));
        queue_item(mk(CMD_DECREASE, 200, 6));
        queue_item(mk(CMD_INSERT, 50, 7));
        queue_item(mk(CMD_INSERT, 60, 7));
        queue_item(mk(CMD_NOP, '1, 1023));
        queue_item(mk(CMD_DECREASE, 0, 1023));
        queue_item(mk(CMD_EXTRACT, 0, 0));
        queue_item(mk(CMD_EXTRACT, 0, 0));
        queue_item(mk(CMD_EXTRACT, 0, 0));
        queue_item(mk(CMD_DECREASE, 1, 0));
        queue_item(mk(CMD_EXTRACT, 0, 0));
        queue_item(mk(CMD_EXTRACT, 0, 0));
        queue_item(mk(CMD_EXTRACT, 0, 0));
        queue_item(mk(CMD_EXTRACT, 0, 0));
        wait_drained();
        // fill to capacity with the sender free-running
        for (int i = 0; i < CAPACITY; i++)
            queue_item(mk(CMD_INSERT, pick_key(), 10'(i)));
        queue_item(mk(CMD_INSERT, 5, 3));
        wait_drained();
        // every id is held now; decrease and extract one item at a time
        drain_pause = 1;
        for (int i = 0; i < 40; i++)
            queue_item(mk(CMD_DECREASE, pick_key(), pick_id(1023)));
        for (int i = 0; i < 100; i++)
            queue_item(mk(CMD_EXTRACT, 0, 0));
        wait_drained();
        drain_pause = 0;
        // random mix
        for (int ph = 0; ph < 2; ph++) begin
            span = (ph == 0) ? 255 : 1023;
            n = 0;
            while (n < ((ph == 0) ? 85 : 80)) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: c = CMD_INSERT;
                    4, 5, 6: c = CMD_EXTRACT;
                    7, 8: c = CMD_DECREASE;
                    default: c = ($urandom_range(0, 3) == 0) ? CMD_NOP : CMD_DECREASE;
                endcase
                queue_item(mk(c, pick_key(), pick_id(span)));
                n++;
            end
            wait_drained();
        end
        repeat (100) @(posedge i_clk);
        $display("Covered %0d results; peak occupancy %0d of %0d entries.",
                 results_seen, max_held, CAPACITY);
        $display("Mixed insert, extract, decrease and unused commands, with empty,");
        $display("absent-id and not-smaller cases and a heap filled to capacity.");
        if (fail_cnt == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #10000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
